// File: rtl/pfs_pkg.sv
// Shared constants, codes and item types for the pixel foreground segmenter.
// Used by every module of the block; depends on nothing else.
package pfs_pkg;

    // Frame and ratio format.
    localparam int FRAME_PIXELS    = 262144;
    localparam int RATIO_FRAC_BITS = 8;
    localparam int RATIO_BITS      = 9 + RATIO_FRAC_BITS;
    localparam int BG_IDX_W        = (FRAME_PIXELS > 1) ? $clog2(FRAME_PIXELS) : 1;
    localparam int BG_W            = 2 * RATIO_BITS;
    localparam int PROD_W          = 2 * RATIO_BITS;
    localparam int LHS_W           = PROD_W + 7;
    localparam int CMP_W           = PROD_W + 8;
    localparam int DIV_STAGES      = RATIO_BITS;
    localparam int FRONT_CNT_W     = $clog2(DIV_STAGES + 1);

    // Field widths.
    localparam int ADDR_W     = 18;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // Queue between front and back, and the output buffer.
    localparam int QDEPTH   = 32;
    localparam int Q_PTR_W  = $clog2(QDEPTH);
    localparam int Q_CNT_W  = $clog2(QDEPTH + 1);
    localparam int ODEPTH   = 8;
    localparam int O_PTR_W  = $clog2(ODEPTH);
    localparam int O_CNT_W  = $clog2(ODEPTH + 1);

    // Luma weights in Q14 and the score gain.
    localparam int GRAY_R     = 4899;
    localparam int GRAY_G     = 9617;
    localparam int GRAY_B     = 1868;
    localparam int GRAY_ROUND = 8192;
    localparam int SCORE_GAIN = 50;
    localparam int ALPHA_ONE  = 256;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_SEG_MODE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_COLOR  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COLOR_FG   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_USE_RATIO  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_USE_MASK   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_GRAY_INPUT = 3'd7;

    typedef enum logic [1:0] {
        SEG_FIXED   = 2'd0,
        SEG_AVERAGE = 2'd1,
        SEG_RATIO   = 2'd2,
        SEG_KEY     = 2'd3
    } seg_mode_t;

    typedef struct packed {
        seg_mode_t   seg_mode;
        logic [7:0]  threshold;
        logic [8:0]  alpha;
        logic [23:0] key_color;
        logic        color_is_foreground;
        logic        use_ratio;
        logic        use_mask;
        logic        gray_input;
    } pfs_cfg_t;

    // Classification carried alongside the ratio dividers.
    typedef struct packed {
        logic              load;
        logic              in_frame;
        logic              err;
        logic              ch_near;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        gray;
        logic [7:0]        mask;
    } pfs_tag_t;

    typedef struct packed {
        pfs_tag_t              tag;
        logic [RATIO_BITS-1:0] ra;
        logic [RATIO_BITS-1:0] rc;
        logic [RATIO_BITS-1:0] kg;
        logic [RATIO_BITS-1:0] kb;
    } pfs_item_t;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [7:0]        value;
        logic              err;
    } pfs_result_t;

endpackage

// File: rtl/pixel_foreground_segmenter_core.sv
// Top level of the pixel foreground segmenter: configuration registers and wiring.
// Depends on pfs_pkg, pfs_front, pfs_queue and pfs_back.
//
// Usage. Pixels enter on the input channel (in_valid / in_stall) with their raster
// address, colour, mask byte and a load flag. A load item writes the background
// store entry for its address and gives no result; a process item gives one result
// (out_address, binary_value, input_error) on the output channel (out_valid /
// out_stall). Results come out in input order.
// Throughput is one pixel per clock while in_stall is low. The front part runs four
// pipelined ratio dividers of RATIO_BITS stages, the back part reads the background
// store, updates it and scores the pixel in three stages.
// The background store has one write and one read port; a pixel that follows a
// write to the same address sees the new value through a bypass register.
// Reset clears the configuration to its defaults and empties the queues; store
// contents are kept and an entry must be loaded before it is used.
// When the receiver stalls, results collect in an eight-entry output buffer and
// then in the 32-entry item queue; in_stall rises once that queue has no credit.
// The user must write configuration via cfg_we, cfg_index and cfg_data only while idle; the block does not enforce it.
module pixel_foreground_segmenter_core (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [pfs_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [pfs_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic                                 mode,
    input  logic [pfs_pkg::ADDR_W-1:0]           pixel_address,
    input  logic [7:0]                           blue,
    input  logic [7:0]                           green,
    input  logic [7:0]                           red,
    input  logic [7:0]                           mask_pixel,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [pfs_pkg::ADDR_W-1:0]           out_address,
    output logic [7:0]                           binary_value,
    output logic                                 input_error
);
    import pfs_pkg::*;

    pfs_cfg_t            cfg_reg;
    logic                q_push;
    pfs_item_t           q_item;
    logic                q_pop;
    pfs_item_t           q_head;
    logic                q_empty;
    logic [Q_CNT_W-1:0]  q_count;
    pfs_result_t         result;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.seg_mode            <= SEG_FIXED;
            cfg_reg.threshold           <= 8'd30;
            cfg_reg.alpha               <= 9'd26;
            cfg_reg.key_color           <= 24'd0;
            cfg_reg.color_is_foreground <= 1'b1;
            cfg_reg.use_ratio           <= 1'b0;
            cfg_reg.use_mask            <= 1'b0;
            cfg_reg.gray_input          <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SEG_MODE:   cfg_reg.seg_mode            <= seg_mode_t'(cfg_data[1:0]);
                REG_THRESHOLD:  cfg_reg.threshold           <= cfg_data[7:0];
                REG_ALPHA:      cfg_reg.alpha               <= cfg_data[8:0];
                REG_KEY_COLOR:  cfg_reg.key_color           <= cfg_data[23:0];
                REG_COLOR_FG:   cfg_reg.color_is_foreground <= cfg_data[0];
                REG_USE_RATIO:  cfg_reg.use_ratio           <= cfg_data[0];
                REG_USE_MASK:   cfg_reg.use_mask            <= cfg_data[0];
                REG_GRAY_INPUT: cfg_reg.gray_input          <= cfg_data[0];
                default:        ;
            endcase
        end
    end

    pfs_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .mode          (mode),
        .pixel_address (pixel_address),
        .blue          (blue),
        .green         (green),
        .red           (red),
        .mask_pixel    (mask_pixel),
        .q_count       (q_count),
        .q_push        (q_push),
        .q_item        (q_item)
    );

    pfs_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_item),
        .pop       (q_pop),
        .head      (q_head),
        .empty     (q_empty),
        .count     (q_count)
    );

    pfs_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_head    (q_head),
        .q_empty   (q_empty),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .result    (result)
    );

    assign out_address  = result.addr;
    assign binary_value = result.value;
    assign input_error  = result.err;

endmodule

// File: rtl/pfs_ratio_div.sv
// Pipelined restoring divider giving the rounded ratio ((num+1)<<F)/(den+1).
// Depends on pfs_pkg; one quotient bit per stage, one new operand pair per cycle.
module pfs_ratio_div (
    input  logic                           clk,
    input  logic [7:0]                     num,
    input  logic [7:0]                     den,
    output logic [pfs_pkg::RATIO_BITS-1:0] ratio
);
    import pfs_pkg::*;

    logic [7:0]            rem_reg  [DIV_STAGES];
    logic [RATIO_BITS-1:0] work_reg [DIV_STAGES];
    logic [8:0]            dvs_reg  [DIV_STAGES];

    logic [8:0]            dvs_in;
    logic [RATIO_BITS-1:0] dividend;

    // Dividend carries the rounding term of half the divisor.
    assign dvs_in   = {1'b0, den} + 9'd1;
    assign dividend = (RATIO_BITS'({1'b0, num} + 9'd1) << RATIO_FRAC_BITS)
                      + RATIO_BITS'(dvs_in >> 1);

    for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
        logic [7:0]            r_in;
        logic [RATIO_BITS-1:0] w_in;
        logic [8:0]            d_in;
        logic [8:0]            trial;
        logic                  take;
        logic [8:0]            diff;

        if (s == 0) begin : g_first
            assign r_in = 8'd0;
            assign w_in = dividend;
            assign d_in = dvs_in;
        end
        else begin : g_rest
            assign r_in = rem_reg[s-1];
            assign w_in = work_reg[s-1];
            assign d_in = dvs_reg[s-1];
        end

        // One restoring step: bring down a bit and subtract if it fits.
        assign trial = {r_in, w_in[RATIO_BITS-1]};
        assign take  = (trial >= d_in);
        assign diff  = trial - d_in;

        always_ff @(posedge clk)
        begin
            rem_reg[s]  <= take ? diff[7:0] : trial[7:0];
            work_reg[s] <= {w_in[RATIO_BITS-2:0], take};
            dvs_reg[s]  <= d_in;
        end
    end

    // A ratio never drops below one LSB.
    assign ratio = (work_reg[DIV_STAGES-1] == '0) ? RATIO_BITS'(1) : work_reg[DIV_STAGES-1];

endmodule

// File: rtl/pfs_front.sv
// Front part: accepts pixels, converts to gray, classifies them and forms ratios.
// Depends on pfs_pkg and pfs_ratio_div; pushes finished items into the queue.
module pfs_front (
    input  logic                         clk,
    input  logic                         rst_n,
    input  pfs_pkg::pfs_cfg_t            cfg,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic                         mode,
    input  logic [pfs_pkg::ADDR_W-1:0]   pixel_address,
    input  logic [7:0]                   blue,
    input  logic [7:0]                   green,
    input  logic [7:0]                   red,
    input  logic [7:0]                   mask_pixel,
    input  logic [pfs_pkg::Q_CNT_W-1:0]  q_count,
    output logic                         q_push,
    output pfs_pkg::pfs_item_t           q_item
);
    import pfs_pkg::*;

    function automatic logic [7:0] absd8(input logic [7:0] x, input logic [7:0] y);
        absd8 = (x > y) ? (x - y) : (y - x);
    endfunction

    logic                   valid_reg [DIV_STAGES];
    pfs_tag_t               tag_reg   [DIV_STAGES];
    logic [FRONT_CNT_W-1:0] inflight_reg;
    logic [FRONT_CNT_W-1:0] inflight_next;

    logic       accept;
    logic [21:0] gsum;
    pfs_tag_t   tag_in;
    logic [7:0] kr;
    logic [7:0] kgc;
    logic [7:0] kbc;
    logic [7:0] num_a;
    logic [7:0] den_a;
    logic [7:0] num_c;
    logic [7:0] den_c;
    logic [RATIO_BITS-1:0] ra;
    logic [RATIO_BITS-1:0] rc;
    logic [RATIO_BITS-1:0] kg;
    logic [RATIO_BITS-1:0] kb;

    // Credit check: items in the divider line plus the queue fill.
    assign in_stall = ((Q_CNT_W+1)'(q_count) + (Q_CNT_W+1)'(inflight_reg))
                      >= (Q_CNT_W+1)'(QDEPTH);
    assign accept   = in_valid && !in_stall;

    assign kr  = cfg.key_color[23:16];
    assign kgc = cfg.key_color[15:8];
    assign kbc = cfg.key_color[7:0];

    // Gray conversion and classification of the incoming pixel.
    assign gsum = 22'(red) * 22'(GRAY_R) + 22'(green) * 22'(GRAY_G)
                + 22'(blue) * 22'(GRAY_B) + 22'(GRAY_ROUND);

    always_comb
    begin
        tag_in.load     = mode;
        tag_in.in_frame = (23'(pixel_address) < 23'(FRAME_PIXELS));
        tag_in.err      = cfg.gray_input &&
                          (cfg.seg_mode == SEG_RATIO || cfg.seg_mode == SEG_KEY);
        tag_in.ch_near  = (absd8(red, kr) <= cfg.threshold) &&
                          (absd8(green, kgc) <= cfg.threshold) &&
                          (absd8(blue, kbc) <= cfg.threshold);
        tag_in.addr     = pixel_address;
        tag_in.gray     = cfg.gray_input ? blue : gsum[21:14];
        tag_in.mask     = mask_pixel;
    end

    // Gray input makes both pixel ratios unity.
    assign num_a = cfg.gray_input ? blue : red;
    assign den_a = cfg.gray_input ? blue : green;
    assign num_c = cfg.gray_input ? blue : red;
    assign den_c = blue;

    pfs_ratio_div u_div_a  (.clk(clk), .num(num_a), .den(den_a), .ratio(ra));
    pfs_ratio_div u_div_c  (.clk(clk), .num(num_c), .den(den_c), .ratio(rc));
    pfs_ratio_div u_div_kg (.clk(clk), .num(kr),    .den(kgc),   .ratio(kg));
    pfs_ratio_div u_div_kb (.clk(clk), .num(kr),    .den(kbc),   .ratio(kb));

    // Tag line running in step with the dividers.
    for (genvar s = 0; s < DIV_STAGES; s++) begin : g_line
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[s] <= 1'b0;
            end
            else
            begin
                valid_reg[s] <= (s == 0) ? accept : valid_reg[(s == 0) ? 0 : s-1];
            end
        end

        always_ff @(posedge clk)
        begin
            tag_reg[s] <= (s == 0) ? tag_in : tag_reg[(s == 0) ? 0 : s-1];
        end
    end

    // Count of items inside the divider line.
    assign inflight_next = inflight_reg + FRONT_CNT_W'(accept)
                         - FRONT_CNT_W'(valid_reg[DIV_STAGES-1]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inflight_reg <= '0;
        end
        else
        begin
            inflight_reg <= inflight_next;
        end
    end

    assign q_push      = valid_reg[DIV_STAGES-1];
    assign q_item.tag  = tag_reg[DIV_STAGES-1];
    assign q_item.ra   = ra;
    assign q_item.rc   = rc;
    assign q_item.kg   = kg;
    assign q_item.kb   = kb;

endmodule

// File: rtl/pfs_queue.sv
// Item queue between the front and back parts of the segmenter.
// Depends on pfs_pkg; the front never pushes into a full queue thanks to credits.
module pfs_queue (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    input  pfs_pkg::pfs_item_t           push_item,
    input  logic                         pop,
    output pfs_pkg::pfs_item_t           head,
    output logic                         empty,
    output logic [pfs_pkg::Q_CNT_W-1:0]  count
);
    import pfs_pkg::*;

    pfs_item_t           slot_reg [QDEPTH];
    logic [Q_PTR_W-1:0]  wr_ptr_reg;
    logic [Q_PTR_W-1:0]  rd_ptr_reg;
    logic [Q_CNT_W-1:0]  count_reg;

    // Storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + Q_PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + Q_PTR_W'(1);
            end
            count_reg <= count_reg + Q_CNT_W'(push) - Q_CNT_W'(pop);
        end
    end

    assign head  = slot_reg[rd_ptr_reg];
    assign empty = (count_reg == '0);
    assign count = count_reg;

endmodule

// File: rtl/pfs_back.sv
// Back part: background store access, running average, scoring and output buffer.
// Depends on pfs_pkg; pops items from the queue and drives the result channel.
module pfs_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  pfs_pkg::pfs_cfg_t           cfg,
    input  pfs_pkg::pfs_item_t          q_head,
    input  logic                        q_empty,
    output logic                        q_pop,
    output logic                        out_valid,
    input  logic                        out_stall,
    output pfs_pkg::pfs_result_t        result
);
    import pfs_pkg::*;

    function automatic logic [RATIO_BITS-1:0] absdr(input logic [RATIO_BITS-1:0] x,
                                                    input logic [RATIO_BITS-1:0] y);
        absdr = (x > y) ? (x - y) : (y - x);
    endfunction

    // Background store, no reset.
    logic [BG_W-1:0]     bg_mem [FRAME_PIXELS];
    logic [BG_W-1:0]     rd_data_reg;

    // Stage 1.
    logic                b1_valid_reg;
    pfs_item_t           b1_item_reg;
    // Last write, for the read that overlapped it.
    logic                wr_valid_reg;
    logic [BG_IDX_W-1:0] wr_addr_reg;
    logic [BG_W-1:0]     wr_data_reg;
    // Stage 2.
    logic                b2_valid_reg;
    pfs_tag_t            b2_tag_reg;
    logic [7:0]          b2_bgc_reg;
    logic [PROD_W-1:0]   b2_p0_reg;
    logic [PROD_W-1:0]   b2_p1_reg;
    logic [PROD_W-1:0]   b2_p2_reg;
    // Stage 3.
    logic                b3_valid_reg;
    pfs_tag_t            b3_tag_reg;
    logic                b3_gray_set_reg;
    logic [LHS_W-1:0]    b3_lhs_reg;
    logic [CMP_W-1:0]    b3_rhs_reg;
    // Output buffer.
    pfs_result_t         obuf_reg [ODEPTH];
    logic [O_PTR_W-1:0]  owr_ptr_reg;
    logic [O_PTR_W-1:0]  ord_ptr_reg;
    logic [O_CNT_W-1:0]  ocount_reg;

    logic [1:0]          binflight;
    logic [BG_IDX_W-1:0] rd_idx;
    logic [BG_IDX_W-1:0] b1_idx;
    logic [BG_W-1:0]     bg;
    logic [8:0]          a_eff;
    logic [8:0]          a_inv;
    logic [16:0]         mix;
    logic [7:0]          upd;
    logic                wr_en;
    logic [BG_W-1:0]     wr_data;
    logic [RATIO_BITS-1:0] bb;
    logic [RATIO_BITS-1:0] bd;
    logic [RATIO_BITS-1:0] x0;
    logic [RATIO_BITS-1:0] y0;
    logic [RATIO_BITS-1:0] x1;
    logic [RATIO_BITS-1:0] y1;
    logic [PROD_W:0]     psum;
    logic [LHS_W-1:0]    lhs;
    logic [CMP_W-1:0]    rhs;
    logic [7:0]          gdiff;
    logic                near;
    logic                fg;
    logic [7:0]          value;
    logic                opush;
    logic                opop;

    // Pop only when the output buffer has room for everything in flight.
    assign binflight = 2'(b1_valid_reg) + 2'(b2_valid_reg) + 2'(b3_valid_reg);
    assign q_pop     = !q_empty &&
                       (((O_CNT_W+1)'(ocount_reg) + (O_CNT_W+1)'(binflight))
                        < (O_CNT_W+1)'(ODEPTH));

    assign rd_idx = BG_IDX_W'(q_head.tag.addr);
    assign b1_idx = BG_IDX_W'(b1_item_reg.tag.addr);

    // Stage 1: background, zero out of frame, with bypass of the write that raced the read.
    always_comb
    begin
        if (!b1_item_reg.tag.in_frame)
        begin
            bg = '0;
        end
        else if (wr_valid_reg && wr_addr_reg == b1_idx)
        begin
            bg = wr_data_reg;
        end
        else
        begin
            bg = rd_data_reg;
        end
    end

    // Running average update of the gray background.
    assign a_eff = (cfg.alpha > 9'(ALPHA_ONE)) ? 9'(ALPHA_ONE) : cfg.alpha;
    assign a_inv = 9'(ALPHA_ONE) - a_eff;
    assign mix   = 17'(a_eff) * 17'(b1_item_reg.tag.gray) + 17'(a_inv) * 17'(bg[7:0])
                 + 17'd128;
    assign upd   = mix[15:8];

    // Store write for loads and for running-average pixels.
    always_comb
    begin
        wr_en = b1_valid_reg && b1_item_reg.tag.in_frame &&
                (b1_item_reg.tag.load || cfg.seg_mode == SEG_AVERAGE);
        if (!b1_item_reg.tag.load)
        begin
            wr_data = BG_W'(upd);
        end
        else if (cfg.seg_mode == SEG_RATIO)
        begin
            wr_data = {b1_item_reg.rc, b1_item_reg.ra};
        end
        else
        begin
            wr_data = BG_W'(b1_item_reg.tag.gray);
        end
    end

    // Ratio deviation operands: background ratios or key ratios.
    assign bb = bg[RATIO_BITS-1:0];
    assign bd = bg[BG_W-1:RATIO_BITS];

    always_comb
    begin
        if (cfg.seg_mode == SEG_RATIO)
        begin
            x0 = absdr(b1_item_reg.ra, bb);
            y0 = bd;
            x1 = absdr(b1_item_reg.rc, bd);
            y1 = bb;
        end
        else
        begin
            x0 = absdr(b1_item_reg.ra, b1_item_reg.kg);
            y0 = b1_item_reg.kg;
            x1 = absdr(b1_item_reg.rc, b1_item_reg.kb);
            y1 = b1_item_reg.kb;
        end
    end

    // Store and stage 1 loading.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            bg_mem[b1_idx] <= wr_data;
        end
        if (q_pop)
        begin
            rd_data_reg <= bg_mem[rd_idx];
            b1_item_reg <= q_head;
        end
        wr_addr_reg <= b1_idx;
        wr_data_reg <= wr_data;
    end

    // Stage 2 payload.
    always_ff @(posedge clk)
    begin
        b2_tag_reg <= b1_item_reg.tag;
        b2_bgc_reg <= (cfg.seg_mode == SEG_AVERAGE) ? upd : bg[7:0];
        b2_p0_reg  <= PROD_W'(x0) * PROD_W'(y0);
        b2_p1_reg  <= PROD_W'(x1) * PROD_W'(y1);
        b2_p2_reg  <= PROD_W'(bb) * PROD_W'(bd);
    end

    // Stage 2: scaled deviation and its bound.
    assign psum  = (PROD_W+1)'(b2_p0_reg) + (PROD_W+1)'(b2_p1_reg);
    assign lhs   = LHS_W'(psum) * LHS_W'(SCORE_GAIN);
    assign rhs   = (cfg.seg_mode == SEG_RATIO)
                 ? CMP_W'(b2_p2_reg) * CMP_W'(cfg.threshold)
                 : CMP_W'(cfg.threshold) << (2 * RATIO_FRAC_BITS);
    assign gdiff = (b2_tag_reg.gray > b2_bgc_reg) ? (b2_tag_reg.gray - b2_bgc_reg)
                                                  : (b2_bgc_reg - b2_tag_reg.gray);

    always_ff @(posedge clk)
    begin
        b3_tag_reg      <= b2_tag_reg;
        b3_gray_set_reg <= (gdiff > cfg.threshold);
        b3_lhs_reg      <= lhs;
        b3_rhs_reg      <= rhs;
    end

    // Stage 3: decision, inversion and mask.
    always_comb
    begin
        near = cfg.use_ratio ? (CMP_W'(b3_lhs_reg) <= b3_rhs_reg) : b3_tag_reg.ch_near;
        case (cfg.seg_mode)
            SEG_FIXED, SEG_AVERAGE: fg = b3_gray_set_reg;
            SEG_RATIO:              fg = !b3_tag_reg.err && (CMP_W'(b3_lhs_reg) > b3_rhs_reg);
            SEG_KEY:                fg = !b3_tag_reg.err && (near == cfg.color_is_foreground);
            default:                fg = 1'b0;
        endcase
        value = fg ? 8'hFF : 8'h00;
        if (cfg.use_mask)
        begin
            value = value & b3_tag_reg.mask;
        end
    end

    assign opush = b3_valid_reg && !b3_tag_reg.load;
    assign opop  = out_valid && !out_stall;

    always_ff @(posedge clk)
    begin
        if (opush)
        begin
            obuf_reg[owr_ptr_reg] <= '{addr: b3_tag_reg.addr, value: value,
                                       err: b3_tag_reg.err};
        end
    end

    // Control state of the back pipeline and output buffer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_valid_reg <= 1'b0;
            b2_valid_reg <= 1'b0;
            b3_valid_reg <= 1'b0;
            wr_valid_reg <= 1'b0;
            owr_ptr_reg  <= '0;
            ord_ptr_reg  <= '0;
            ocount_reg   <= '0;
        end
        else
        begin
            b1_valid_reg <= q_pop;
            b2_valid_reg <= b1_valid_reg;
            b3_valid_reg <= b2_valid_reg;
            wr_valid_reg <= wr_en;
            if (opush)
            begin
                owr_ptr_reg <= owr_ptr_reg + O_PTR_W'(1);
            end
            if (opop)
            begin
                ord_ptr_reg <= ord_ptr_reg + O_PTR_W'(1);
            end
            ocount_reg <= ocount_reg + O_CNT_W'(opush) - O_CNT_W'(opop);
        end
    end

    assign out_valid = (ocount_reg != '0);
    assign result    = obuf_reg[ord_ptr_reg];

`ifndef SYNTH
    // A result never lands in a full output buffer.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        opush |-> (ocount_reg != O_CNT_W'(ODEPTH)) || opop)
        else $error("output buffer overflow");

    // Credits keep buffered plus in-flight items within the buffer depth.
    a_credit: assert property (@(posedge clk) disable iff (!rst_n)
        ((O_CNT_W+1)'(ocount_reg) + (O_CNT_W+1)'(binflight)) <= (O_CNT_W+1)'(ODEPTH))
        else $error("back pipeline credit exceeded");

    // The queue is never popped while empty.
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("pop from empty queue");

    // A store write is always followed by its bypass record.
    a_bypass: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |=> wr_valid_reg && (wr_addr_reg == $past(b1_idx)))
        else $error("write bypass record lost");
`endif

endmodule
